### sv/idct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idct_pkg
// Shared constants, types and the 1-D transform arithmetic for the 8x8 IDCT.
// ----------------------------------------------------------------------------
package idct_pkg;

  localparam int CoefW = 16;
  localparam int RowW  = 8 * CoefW;
  localparam int PixW  = 8;
  localparam int Depth = 8;
  localparam int AddrW = 3;

  localparam logic signed [31:0] ColBias = 32'sd512;
  localparam logic signed [31:0] RowBias = 32'sd65536 + (32'sd128 <<< 17);

  typedef logic signed [CoefW-1:0] coef_t;
  typedef coef_t [7:0]             vec_t;
  typedef logic signed [35:0]      acc_t;
  typedef acc_t [7:0]              prod_t;

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_COL  = 6'b000010,
    ST_RD   = 6'b000100,
    ST_S1   = 6'b001000,
    ST_S2   = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  // first half: even/odd products, registered by caller
  function automatic prod_t idct_stage1(input vec_t v);
    coef_t s04, d04, s17, s35;
    prod_t p;
    begin
      s04 = coef_t'(v[0] + v[4]);
      d04 = coef_t'(v[0] - v[4]);
      s17 = coef_t'(v[1] + v[7]);
      s35 = coef_t'(v[3] + v[5]);
      p[0] = acc_t'(s04) * 36'sd4096;
      p[1] = acc_t'(d04) * 36'sd4096;
      p[2] = acc_t'(v[2]) * 36'sd2217 + acc_t'(v[6]) * -36'sd5351;
      p[3] = acc_t'(v[2]) * 36'sd5352 + acc_t'(v[6]) * 36'sd2217;
      p[4] = acc_t'(v[7]) * -36'sd6812 + acc_t'(v[3]) * -36'sd8035
           + acc_t'(s17) * 36'sd1130 + acc_t'(s35) * 36'sd4816;
      p[5] = acc_t'(v[5]) * 36'sd6812 + acc_t'(v[1]) * -36'sd1598
           + acc_t'(s17) * 36'sd4816 + acc_t'(s35) * -36'sd5682;
      p[6] = acc_t'(v[7]) * -36'sd8035 + acc_t'(v[3]) * 36'sd4551
           + acc_t'(s17) * 36'sd4816 + acc_t'(s35) * -36'sd5682;
      p[7] = acc_t'(v[5]) * -36'sd1598 + acc_t'(v[1]) * 36'sd4551
           + acc_t'(s17) * 36'sd1130 + acc_t'(s35) * 36'sd4816;
      return p;
    end
  endfunction

  // second half: butterflies, bias, shift; returns unsaturated results
  function automatic prod_t idct_stage2(input prod_t p, input logic row_pass);
    acc_t x0, x1, x2, x3, bias;
    prod_t o;
    begin
      x0 = p[0] + p[3];
      x3 = p[0] - p[3];
      x1 = p[1] + p[2];
      x2 = p[1] - p[2];
      bias = row_pass ? acc_t'(RowBias) : acc_t'(ColBias);
      o[0] = x0 + bias + p[7];
      o[7] = x0 + bias - p[7];
      o[1] = x1 + bias + p[6];
      o[6] = x1 + bias - p[6];
      o[2] = x2 + bias + p[5];
      o[5] = x2 + bias - p[5];
      o[3] = x3 + bias + p[4];
      o[4] = x3 + bias - p[4];
      for (int k = 0; k < 8; k++) begin
        o[k] = row_pass ? (o[k] >>> 17) : (o[k] >>> 10);
      end
      return o;
    end
  endfunction

  function automatic coef_t sat16(input acc_t a);
    begin
      if (a > 36'sd32767) return 16'sh7fff;
      if (a < -36'sd32768) return 16'sh8000;
      return coef_t'(a);
    end
  endfunction

  function automatic logic [PixW-1:0] clamp8(input acc_t a);
    begin
      if (a < 36'sd0) return 8'd0;
      if (a > 36'sd255) return 8'd255;
      return a[PixW-1:0];
    end
  endfunction

endpackage

### sv/idct_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idct_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module idct_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/idct_8x8_integer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idct_8x8_integer
// 8x8 accurate integer inverse DCT, one coefficient row in and one pixel row out per transfer.
// ----------------------------------------------------------------------------
// Each item is one coefficient row. Rows are taken one a cycle into eight
// 16-bit RAM banks, skewed so that either a whole row or a whole column is
// read at once. After the eighth row the column pass runs in place through
// the shared 1-D unit over the eight columns. Each pixel row is then read
// (ST_RD) and transformed (ST_S1, ST_S2) and held in the output register
// until taken; the next row starts after that. From the eighth row on no
// row is taken until the last pixel row of the block is delivered.
module idct_8x8_integer
  import idct_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [RowW-1:0] s_tdata,  // coef_a .. coef_h, 16 bits each
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [63:0]     m_tdata,  // pix_a .. pix_h, 8 bits each
  output logic [2:0]      m_tuser,  // out_row
  output logic            m_tlast   // block_end
);

  state_t           state;
  logic [AddrW-1:0] wcnt;
  logic [AddrW-1:0] idx1;
  logic [AddrW-1:0] idx_rd;
  logic [AddrW-1:0] idx2;
  logic [AddrW-1:0] rrow;
  logic             tdone;
  logic             rd_v;
  logic             p_v;

  logic             bank_we;
  coef_t            rdata [8];
  vec_t             s_vec, col_vec, row_vec, in_vec, res_vec;
  prod_t            p_reg, o_comb;
  logic             in_row_pass;
  logic [63:0]      pix_row;

  assign s_tready = (state == ST_LOAD);
  assign s_vec    = s_tdata;
  assign bank_we  = (s_tvalid && s_tready) || ((state == ST_COL) && p_v);

  // bank b holds row r, column c at address r where (r + c) mod 8 == b
  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [AddrW-1:0] wsel;
    logic [AddrW-1:0] waddr;
    logic [AddrW-1:0] raddr;
    coef_t            wdata;

    assign wsel  = AddrW'(b) - ((state == ST_COL) ? idx2 : wcnt);
    assign waddr = (state == ST_COL) ? wsel : wcnt;
    assign wdata = (state == ST_COL) ? res_vec[wsel] : s_vec[wsel];
    assign raddr = (state == ST_COL) ? AddrW'(b) - idx1 : rrow;

    idct_ram #(.Width(CoefW), .Depth(Depth)) u_ram (
      .clk(clk), .we(bank_we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata[b])
    );
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      col_vec[k] = rdata[AddrW'(k) + idx_rd];
      row_vec[k] = rdata[AddrW'(k) + rrow];
    end
    in_vec      = (state == ST_COL) ? col_vec : row_vec;
    in_row_pass = (state != ST_COL);
    o_comb      = idct_stage2(p_reg, in_row_pass);
    for (int k = 0; k < 8; k++) begin
      res_vec[k]              = sat16(o_comb[k]);
      pix_row[k*PixW +: PixW] = clamp8(o_comb[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      wcnt     <= '0;
      idx1     <= '0;
      idx_rd   <= '0;
      idx2     <= '0;
      rrow     <= '0;
      tdone    <= 1'b0;
      rd_v     <= 1'b0;
      p_v      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (s_tvalid) begin
            wcnt <= wcnt + 3'd1;
            if (wcnt == 3'd7) begin
              state <= ST_COL;
              idx1  <= '0;
              tdone <= 1'b0;
              rd_v  <= 1'b0;
              p_v   <= 1'b0;
            end
          end
        end
        ST_COL: begin
          rd_v   <= !tdone;
          idx_rd <= idx1;
          if (!tdone) begin
            idx1 <= idx1 + 3'd1;
            if (idx1 == 3'd7) begin
              tdone <= 1'b1;
            end
          end
          p_v   <= rd_v;
          idx2  <= idx_rd;
          p_reg <= idct_stage1(in_vec);
          if (p_v && idx2 == 3'd7) begin
            state <= ST_RD;
            rrow  <= '0;
          end
        end
        ST_RD: begin
          state <= ST_S1;
        end
        ST_S1: begin
          p_reg <= idct_stage1(in_vec);
          state <= ST_S2;
        end
        ST_S2: begin
          m_tdata  <= pix_row;
          m_tuser  <= rrow;
          m_tlast  <= (rrow == 3'd7);
          m_tvalid <= 1'b1;
          state    <= ST_OUT;
        end
        ST_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            rrow     <= rrow + 3'd1;
            state    <= (rrow == 3'd7) ? ST_LOAD : ST_RD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule
